// ===== src/interval_coverage_threshold_max_defines.svh =====
// assertion macros shared by the coverage sweep rtl
`ifndef INTERVAL_COVERAGE_THRESHOLD_MAX_DEFINES_SVH
`define INTERVAL_COVERAGE_THRESHOLD_MAX_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ICTM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ictm assertion failed");

// next-cycle implication, checked outside reset
`define ICTM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ictm assertion failed");

`endif

// ===== src/ictm_pkg.sv =====
// shared types and constants for the interval coverage sweep
`timescale 1ns / 1ps
`default_nettype none

package ictm_pkg;

  localparam int COORD_BITS    = 10;
  localparam int NUM_COORDS    = 1 << COORD_BITS;
  localparam int MAX_INTERVALS = 1024;
  localparam int CNT_BITS      = $clog2(MAX_INTERVALS + 1);
  localparam int DELTA_BITS    = CNT_BITS + 1;
  localparam int COV_BITS      = 11;
  localparam int CMP_BITS      = (CNT_BITS > COV_BITS) ? CNT_BITS : COV_BITS;

  typedef logic [COORD_BITS-1:0]        coord_t;
  typedef logic signed [DELTA_BITS-1:0] delta_t;
  typedef logic signed [COORD_BITS:0]   best_t;
  typedef logic [CNT_BITS-1:0]          count_t;
  typedef logic [COV_BITS-1:0]          cov_t;

  localparam coord_t COORD_TOP     = {COORD_BITS{1'b1}};
  localparam count_t COUNT_LIMIT   = CNT_BITS'(MAX_INTERVALS);
  localparam cov_t   COV_RESET     = COV_BITS'(1);

  typedef enum logic [1:0] {
    OP_INC,
    OP_DEC,
    OP_SWEEP,
    OP_ZERO
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HI,
    ST_SWEEP
  } state_t;

  typedef struct packed {
    logic   valid;
    op_t    op;
    coord_t addr;
  } issue_t;

  typedef struct packed {
    logic  valid;
    best_t best;
  } result_t;

endpackage

`default_nettype wire

// ===== src/interval_coverage_threshold_max.sv =====
// top level: interval intake, batch sweep control and result register
//
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------
//  cfg     | cfg_valid / cfg_ready | min_coverage
//  in      | in_valid / in_ready   | interval_start, interval_end, last_interval
//  out     | out_valid / out_ready | best_coordinate
//
// an interval uses one memory update slot each for +1 (ST_IDLE) and -1 (ST_HI)
// an item marked last adds a sweep of all 2^COORD_BITS entries (1024), one entry a cycle
// unless the final read waits; out_valid is registered from the pipeline stage that holds that final read
// after reset a clearing pass over all 1024 entries holds in_ready low; cfg is always taken
// the final sweep read waits while a previous result has not been transferred

`timescale 1ns / 1ps
`default_nettype none
`include "interval_coverage_threshold_max_defines.svh"

module interval_coverage_threshold_max
  import ictm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [COV_BITS-1:0]   min_coverage,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [COORD_BITS-1:0] interval_start,
  input  wire logic [COORD_BITS-1:0] interval_end,
  input  wire logic                  last_interval,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic signed [COORD_BITS:0] best_coordinate
);

  state_t  state;
  state_t  state_next;
  cov_t    min_cov;
  coord_t  cnt;
  coord_t  hi_addr;
  logic    hi_do;
  logic    last_pend;
  count_t  seen;
  issue_t  iss;
  result_t res;
  logic    in_take;
  logic    item_ok;
  logic    sweep_go;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_cov <= COV_RESET;
    end else if (cfg_valid) begin
      min_cov <= min_coverage;
    end
  end

  assign in_take  = in_valid && in_ready;
  assign item_ok  = (interval_start <= interval_end) && (seen < COUNT_LIMIT);
  assign sweep_go = (cnt != COORD_TOP) || !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    iss.valid  = 1'b0;
    iss.op     = OP_ZERO;
    iss.addr   = cnt;
    case (state)
      ST_CLEAR: begin
        iss.valid = 1'b1;
        if (cnt == COORD_TOP) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready  = 1'b1;
        iss.valid = in_valid && item_ok;
        iss.op    = OP_INC;
        iss.addr  = interval_start;
        if (in_valid) begin
          state_next = ST_HI;
        end
      end
      ST_HI: begin
        iss.valid  = hi_do;
        iss.op     = OP_DEC;
        iss.addr   = hi_addr;
        state_next = last_pend ? ST_SWEEP : ST_IDLE;
      end
      ST_SWEEP: begin
        iss.valid = sweep_go;
        iss.op    = OP_SWEEP;
        if (sweep_go && (cnt == COORD_TOP)) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      seen      <= '0;
      hi_do     <= 1'b0;
      last_pend <= 1'b0;
    end else begin
      if ((state == ST_CLEAR) || ((state == ST_SWEEP) && sweep_go)) begin
        cnt <= cnt + coord_t'(1);
      end
      if (in_take) begin
        hi_do     <= item_ok && (interval_end != COORD_TOP);
        last_pend <= last_interval;
        if (item_ok) begin
          seen <= seen + count_t'(1);
        end
      end
      if ((state == ST_HI) && last_pend) begin
        seen <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      hi_addr <= interval_end + coord_t'(1);
    end
  end

  ictm_update_pipe u_pipe (
    .clk     (clk),
    .rst     (rst),
    .iss     (iss),
    .min_cov (min_cov),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      best_coordinate <= res.best;
    end
  end

  `ICTM_ASSERT_NOW(a_no_result_overwrite, res.valid, !out_valid)
  `ICTM_ASSERT_NOW(a_hi_follows_take, state == ST_HI, $past(in_valid && in_ready))
  `ICTM_ASSERT_NOW(a_seen_bounded, 1'b1, seen <= COUNT_LIMIT)

endmodule

`default_nettype wire

// ===== src/ictm_update_pipe.sv =====
// difference memory with read-modify-write pipeline and prefix-sum sweep
`timescale 1ns / 1ps
`default_nettype none
`include "interval_coverage_threshold_max_defines.svh"

module ictm_update_pipe
  import ictm_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire issue_t  iss,
  input  wire cov_t    min_cov,
  output result_t      res
);

  delta_t mem [NUM_COORDS];
  delta_t rdata;
  issue_t p;
  logic   fwd_hit;
  delta_t fwd_data;

  delta_t rd;
  delta_t wdata;
  delta_t cov;
  delta_t cov_base;
  delta_t cov_next;
  best_t  best;
  best_t  best_base;
  best_t  best_next;
  logic [CMP_BITS-1:0] cov_mag;
  logic [CMP_BITS-1:0] thr;

  // memory read and write-back
  always_ff @(posedge clk) begin
    rdata <= mem[iss.addr];
    if (p.valid) begin
      mem[p.addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p.valid <= 1'b0;
      fwd_hit <= 1'b0;
    end else begin
      p.valid <= iss.valid;
      // the write landing this edge is missed by the read issued at the same edge
      fwd_hit <= iss.valid && p.valid && (iss.addr == p.addr);
    end
    p.op     <= iss.op;
    p.addr   <= iss.addr;
    fwd_data <= wdata;
  end

  assign rd = fwd_hit ? fwd_data : rdata;

  always_comb begin
    case (p.op)
      OP_INC:  wdata = rd + delta_t'(1);
      OP_DEC:  wdata = rd - delta_t'(1);
      default: wdata = '0;
    endcase
  end

  // running coverage over the sweep
  assign cov_base  = (p.addr == '0) ? delta_t'(0) : cov;
  assign best_base = (p.addr == '0) ? best_t'(-1) : best;
  assign cov_next  = cov_base + rd;
  assign cov_mag   = CMP_BITS'(cov_next[CNT_BITS-1:0]);
  assign thr       = CMP_BITS'(min_cov);
  assign best_next = (cov_mag >= thr) ? best_t'({1'b0, p.addr}) : best_base;

  always_ff @(posedge clk) begin
    if (p.valid && (p.op == OP_SWEEP)) begin
      cov  <= cov_next;
      best <= best_next;
    end
  end

  assign res.valid = p.valid && (p.op == OP_SWEEP) && (p.addr == COORD_TOP);
  assign res.best  = best_next;

  `ICTM_ASSERT_NOW(a_fwd_after_write, fwd_hit, $past(p.valid))
  `ICTM_ASSERT_NOW(a_cov_nonneg, p.valid && (p.op == OP_SWEEP), !cov_next[DELTA_BITS-1])

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// testbench for the interval coverage sweep: directed and random batches
`timescale 1ns / 1ps

module tb;
  import ictm_pkg::*;

  typedef enum int {
    SHAPE_REVERSED,
    SHAPE_TO_TOP,
    SHAPE_FROM_ZERO,
    SHAPE_POINT,
    SHAPE_CLUSTER
  } shape_t;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   cfg_valid = 1'b0;
  logic   cfg_ready;
  cov_t   min_coverage = COV_RESET;
  logic   in_valid = 1'b0;
  logic   in_ready;
  coord_t interval_start = '0;
  coord_t interval_end = '0;
  logic   last_interval = 1'b0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  best_t  best_coordinate;

  // predictor state: difference memory, batch count and threshold
  int    delta_mem [NUM_COORDS];
  int    batch_count = 0;
  int    cov_threshold = 1;
  best_t best_due [$];

  int    mismatch_count = 0;
  int    intervals_sent = 0;
  int    idle_pct = 25;
  int    ready_hold = 0;
  best_t seen_best;

  interval_coverage_threshold_max DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .min_coverage   (min_coverage),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .interval_start (interval_start),
    .interval_end   (interval_end),
    .last_interval  (last_interval),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .best_coordinate(best_coordinate)
  );

  always #1 clk = ~clk;

  // receiver stalls in random bursts while idle_pct is nonzero
  always @(posedge clk) begin
    if (idle_pct == 0) begin
      out_ready <= 1'b1;
    end else if (ready_hold > 0) begin
      out_ready <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      out_ready <= 1'b0;
      ready_hold <= $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (best_due.size() == 0) begin
        $error("best_coordinate: no result due, got %0d", best_coordinate);
        mismatch_count++;
      end else begin
        seen_best = best_due.pop_front();
        if (best_coordinate !== seen_best) begin
          $error("best_coordinate: expected %0d, got %0d", seen_best, best_coordinate);
          mismatch_count++;
        end
      end
    end
  end

  function automatic void fold_interval(coord_t s, coord_t e, logic last);
    int    cov;
    best_t best;
    if (s <= e && batch_count < MAX_INTERVALS) begin
      delta_mem[s] += 1;
      if (e != COORD_TOP) delta_mem[int'(e) + 1] -= 1;
      batch_count++;
    end
    if (last) begin
      cov = 0;
      best = best_t'(-1);
      for (int c = 0; c < NUM_COORDS; c++) begin
        cov += delta_mem[c];
        if (cov >= cov_threshold) best = best_t'(c);
        delta_mem[c] = 0;
      end
      batch_count = 0;
      best_due.push_back(best);
    end
  endfunction

  task automatic send_interval(int s, int e, bit last);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    interval_start <= coord_t'(s);
    interval_end <= coord_t'(e);
    last_interval <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    fold_interval(coord_t'(s), coord_t'(e), last);
    intervals_sent++;
  endtask

  // sender holds off until every due result has been transferred
  task automatic drain_results();
    in_valid <= 1'b0;
    while (best_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_threshold(int v);
    cfg_valid <= 1'b1;
    min_coverage <= cov_t'(v);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cov_threshold = v;
  endtask

  task automatic test_directed_extremes();
    write_threshold(1);
    send_interval(0, 0, 1'b1);
    send_interval(1023, 1023, 1'b1);
    send_interval(0, 1023, 1'b1);
    // reversed intervals alone leave an empty batch
    send_interval(5, 3, 1'b1);
    send_interval(1023, 0, 1'b1);
    send_interval(100, 200, 1'b0);
    send_interval(150, 300, 1'b0);
    send_interval(1023, 0, 1'b1);
    drain_results();
  endtask

  task automatic test_threshold_overlap();
    write_threshold(2);
    send_interval(10, 500, 1'b0);
    send_interval(400, 900, 1'b0);
    send_interval(600, 1023, 1'b1);
    send_interval(0, 1023, 1'b0);
    send_interval(0, 0, 1'b1);
    drain_results();
    write_threshold(3);
    send_interval(0, 1023, 1'b0);
    send_interval(0, 1023, 1'b0);
    send_interval(0, 1023, 1'b1);
    send_interval(512, 511, 1'b1);
    drain_results();
  endtask

  // zero threshold: every coordinate qualifies, even with an empty batch
  task automatic test_zero_threshold();
    write_threshold(0);
    send_interval(5, 3, 1'b1);
    send_interval(200, 300, 1'b1);
    drain_results();
  endtask

  // intervals beyond the batch limit are dropped, their last mark still counts
  task automatic test_batch_overflow();
    write_threshold(1024);
    send_interval(700, 300, 1'b0);
    for (int i = 0; i < MAX_INTERVALS; i++)
      send_interval($urandom_range(0, 300), $urandom_range(600, 1023), 1'b0);
    repeat (5) send_interval(0, 1023, 1'b0);
    send_interval(0, 1023, 1'b1);
    drain_results();
  endtask

  task automatic test_random_batches();
    int     target;
    int     size;
    int     center;
    int     lo;
    int     hi;
    int     r;
    shape_t shape;
    target = intervals_sent + 850;
    while (intervals_sent < target) begin
      r = $urandom_range(0, 2);
      if (intervals_sent > target - 170) idle_pct = 0;
      else idle_pct = (r == 0) ? 0 : (r == 1) ? 20 : 50;
      r = $urandom_range(0, 9);
      if (r < 4) write_threshold(1);
      else if (r < 7) write_threshold($urandom_range(2, 4));
      else if (r < 9) write_threshold($urandom_range(5, 12));
      else write_threshold($urandom_range(13, 40));
      repeat ($urandom_range(2, 6)) begin
        size = $urandom_range(1, 30);
        center = $urandom_range(0, 1023);
        for (int i = 1; i <= size; i++) begin
          r = $urandom_range(0, 9);
          shape = (r < 4) ? shape_t'(r) : SHAPE_CLUSTER;
          case (shape)
            SHAPE_REVERSED: begin
              lo = $urandom_range(1, 1023);
              hi = $urandom_range(0, lo - 1);
            end
            SHAPE_TO_TOP: begin
              lo = $urandom_range(0, 1023);
              hi = 1023;
            end
            SHAPE_FROM_ZERO: begin
              lo = 0;
              hi = $urandom_range(0, 1023);
            end
            SHAPE_POINT: begin
              lo = $urandom_range(0, 1023);
              hi = lo;
            end
            default: begin
              // overlapping intervals around one center build up coverage
              lo = center - int'($urandom_range(0, 200));
              hi = center + int'($urandom_range(0, 200));
              if (lo < 0) lo = 0;
              if (hi > 1023) hi = 1023;
            end
          endcase
          send_interval(lo, hi, i == size);
        end
      end
      drain_results();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed_extremes();
    test_threshold_overlap();
    test_zero_threshold();
    test_batch_overflow();
    test_random_batches();
    repeat (1100) @(posedge clk);
    if (mismatch_count == 0 && best_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/ictm_pkg.sv
src/ictm_update_pipe.sv
src/interval_coverage_threshold_max.sv
tb/sv/tb.sv
